FILE: rtl/lzfd_pkg.sv
// Shared types and constants for the LZSS flag-byte decoder.
package lzfd_pkg;

    localparam int CODE_W   = 8;
    localparam int COUNT_W  = 21;
    localparam int OFF_W    = 12;
    localparam int LEN_W    = 6;
    localparam int FLAG_W   = 9;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int MIN_LEN  = 3;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_CAP  = 1'b1;

    localparam logic [COUNT_W-1:0] CAP_RESET = 21'h100000;
    localparam logic [FLAG_W-1:0]  FLAG_MARK = 9'h100;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [1:0] kind;
        logic       run_last;
    } out_item_t;

    typedef enum logic {
        PH_TOKEN,
        PH_MATCH_HI
    } phase_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LIT,
        OP_COPY
    } cmd_op_t;

    typedef enum logic [1:0] {
        TERM_NONE,
        TERM_OK,
        TERM_FAIL
    } term_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [7:0]        data;
        logic [OFF_W-1:0]  off;
        logic [LEN_W-1:0]  len;
        term_t             term;
    } cmd_t;

    typedef struct packed {
        logic                mode;
        logic [COUNT_W-1:0]  capacity;
    } cfg_t;

endpackage

FILE: rtl/lzfd_front.sv
// Front end: parses flag bytes and tokens, checks limits, issues commands.
module lzfd_front #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lzfd_pkg::cfg_t    cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  lzfd_pkg::in_item_t s_data,
    input  logic              q_full,
    output logic              q_push,
    output lzfd_pkg::cmd_t    q_cmd
);
    import lzfd_pkg::*;

    localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(HISTORY_DEPTH);

    logic [COUNT_W-1:0] oc_reg, oc_next;
    logic [FLAG_W-1:0]  flag_reg, flag_next;
    phase_t             phase_reg, phase_next;
    logic [7:0]         lo_reg, lo_next;
    logic               drain_reg, drain_next;

    logic               accept;
    logic [7:0]         b;
    logic               last;
    logic [OFF_W-1:0]   off;
    logic [LEN_W-1:0]   len;
    logic               full_cap;
    logic [COUNT_W-1:0] room;
    logic [LEN_W-1:0]   len_eff;
    logic               bad_off;
    logic               failed;
    cmd_t               cmd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.code_byte;
    assign last    = s_data.stream_end;

    always_comb begin
        if (cfg.mode) begin
            off = {1'b0, b, lo_reg[7:5]};
            len = LEN_W'(lo_reg[4:0]) + LEN_W'(MIN_LEN);
        end else begin
            off = {b, lo_reg[7:4]};
            len = LEN_W'(lo_reg[3:0]) + LEN_W'(MIN_LEN);
        end
    end

    assign full_cap = oc_reg >= cfg.capacity;
    assign room     = cfg.capacity - oc_reg;
    assign len_eff  = full_cap ? '0 :
                      (room < COUNT_W'(len)) ? room[LEN_W-1:0] : len;
    assign bad_off  = (off == '0) || (COUNT_W'(off) > oc_reg) || (COUNT_W'(off) > DEPTH_C);

    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            if (drain_reg || last) begin
                phase_next = PH_TOKEN;
            end else if (phase_reg == PH_MATCH_HI) begin
                phase_next = PH_TOKEN;
            end else if (flag_reg > FLAG_W'(1) && !flag_reg[0]) begin
                phase_next = PH_MATCH_HI;
            end
        end
    end

    always_comb begin
        oc_next    = oc_reg;
        flag_next  = flag_reg;
        lo_next    = lo_reg;
        drain_next = drain_reg;
        failed     = 1'b0;
        cmd.op     = OP_NONE;
        cmd.data   = b;
        cmd.off    = off;
        cmd.len    = len_eff;
        cmd.term   = TERM_NONE;
        if (accept && !drain_reg) begin
            if (phase_reg == PH_TOKEN) begin
                if (flag_reg <= FLAG_W'(1)) begin
                    flag_next = FLAG_MARK | FLAG_W'(b);
                end else if (flag_reg[0]) begin
                    if (full_cap) begin
                        failed = 1'b1;
                    end else begin
                        cmd.op    = OP_LIT;
                        oc_next   = oc_reg + COUNT_W'(1);
                        flag_next = flag_reg >> 1;
                    end
                end else begin
                    lo_next = b;
                end
            end else begin
                if (bad_off) begin
                    failed = 1'b1;
                end else begin
                    if (len_eff != '0) begin
                        cmd.op = OP_COPY;
                    end
                    oc_next   = oc_reg + COUNT_W'(len_eff);
                    flag_next = flag_reg >> 1;
                end
            end
            if (failed) begin
                cmd.term   = TERM_FAIL;
                drain_next = 1'b1;
            end else if (last) begin
                cmd.term = TERM_OK;
            end
        end
        if (accept && last) begin
            oc_next    = '0;
            flag_next  = '0;
            lo_next    = '0;
            drain_next = 1'b0;
        end
    end

    assign q_cmd  = cmd;
    assign q_push = accept && ((cmd.op != OP_NONE) || (cmd.term != TERM_NONE));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oc_reg    <= '0;
            flag_reg  <= '0;
            phase_reg <= PH_TOKEN;
            lo_reg    <= '0;
            drain_reg <= 1'b0;
        end else begin
            oc_reg    <= oc_next;
            flag_reg  <= flag_next;
            phase_reg <= phase_next;
            lo_reg    <= lo_next;
            drain_reg <= drain_next;
        end
    end

endmodule

FILE: rtl/lzfd_queue.sv
// Small command queue between the parser and the output engine.
module lzfd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  lzfd_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output lzfd_pkg::cmd_t head_cmd
);
    import lzfd_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == QCNT_W'(QDEPTH);
    assign not_empty = count_reg != '0;
    assign head_cmd  = entry_reg[rd_ptr_reg];

    assign wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
    assign count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full || pop) else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty) else $error("queue pop while empty");

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == QCNT_W'(QDEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

FILE: rtl/lzfd_back.sv
// Output engine: history ring RAM, match copy sequencing and result register.
module lzfd_back #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_not_empty,
    input  lzfd_pkg::cmd_t      q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output lzfd_pkg::out_item_t m_data
);
    import lzfd_pkg::*;

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = (AW + 1 > OFF_W) ? AW + 1 : OFF_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(HISTORY_DEPTH);

    logic [7:0]       hist_mem [HISTORY_DEPTH];
    logic [7:0]       rd_reg;
    logic [7:0]       byp_reg;
    logic             hit_reg;

    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [AW-1:0]    iwp_reg, iwp_next;

    logic             b_valid_reg;
    logic [AW-1:0]    b_addr_reg;
    logic             b_write_reg;
    logic             b_mem_reg;
    logic [7:0]       b_lit_reg;
    logic [1:0]       b_kind_reg;
    logic             b_last_reg;

    logic             m_valid_reg;
    out_item_t        m_data_reg;

    logic [LEN_W-1:0] nbytes;
    logic [LEN_W-1:0] total;
    logic             is_byte;
    logic             is_final;
    logic             out_free;
    logic             b_free;
    logic             issue;
    logic             re;
    logic             b_we;
    logic [7:0]       b_data;
    logic [CW-1:0]    iwp_ext;
    logic [CW-1:0]    off_ext;
    logic [AW-1:0]    raddr;

    always_comb begin
        case (q_head.op)
            OP_LIT:  nbytes = LEN_W'(1);
            OP_COPY: nbytes = q_head.len;
            default: nbytes = '0;
        endcase
    end

    assign total    = nbytes + LEN_W'(q_head.term != TERM_NONE);
    assign is_byte  = pos_reg < nbytes;
    assign is_final = (pos_reg + LEN_W'(1)) == total;
    assign out_free = !m_valid_reg || m_ready;
    assign b_free   = !b_valid_reg || out_free;
    assign issue    = q_not_empty && b_free;
    assign q_pop    = issue && is_final;
    assign re       = issue && is_byte && (q_head.op == OP_COPY);
    assign b_we     = b_valid_reg && out_free && b_write_reg;
    assign b_data   = b_mem_reg ? (hit_reg ? byp_reg : rd_reg) : b_lit_reg;

    assign iwp_ext = CW'(iwp_reg);
    assign off_ext = CW'(q_head.off);
    assign raddr   = (iwp_ext >= off_ext) ? AW'(iwp_ext - off_ext)
                                          : AW'(iwp_ext + DEPTH_C - off_ext);

    assign pos_next = issue ? (is_final ? '0 : pos_reg + LEN_W'(1)) : pos_reg;
    assign iwp_next = (issue && is_byte) ?
                      ((iwp_reg == LAST_ADDR) ? '0 : iwp_reg + AW'(1)) : iwp_reg;

    always_ff @(posedge aclk) begin
        if (b_we) begin
            hist_mem[b_addr_reg] <= b_data;
        end
        if (re) begin
            rd_reg  <= hist_mem[raddr];
            hit_reg <= b_we && (b_addr_reg == raddr);
            byp_reg <= b_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            b_addr_reg  <= iwp_reg;
            b_write_reg <= is_byte;
            b_mem_reg   <= is_byte && (q_head.op == OP_COPY);
            b_lit_reg   <= is_byte ? q_head.data : 8'd0;
            b_kind_reg  <= is_byte ? KIND_BYTE :
                           (q_head.term == TERM_OK) ? KIND_OK : KIND_FAIL;
            b_last_reg  <= is_final;
        end
        if (out_free && b_valid_reg) begin
            m_data_reg.pixel_byte <= b_data;
            m_data_reg.kind       <= b_kind_reg;
            m_data_reg.run_last   <= b_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            iwp_reg     <= '0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            iwp_reg <= iwp_next;
            if (issue) begin
                b_valid_reg <= 1'b1;
            end else if (out_free) begin
                b_valid_reg <= 1'b0;
            end
            if (out_free) begin
                m_valid_reg <= b_valid_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_not_empty |-> pos_reg < total) else $error("copy position past command");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !out_free) |=> b_valid_reg && $stable(b_kind_reg))
        else $error("stalled stage lost its result");

    a_term_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && b_kind_reg != KIND_BYTE) |-> !b_write_reg)
        else $error("status result writes history");

endmodule

FILE: rtl/lzfd_top_cfg.sv
// Configuration registers behind the APB-style port.
module lzfd_top_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lzfd_pkg::PADDR_W-1:0]  paddr,
    input  logic [lzfd_pkg::PDATA_W-1:0]  pwdata,
    output logic [lzfd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output lzfd_pkg::cfg_t                cfg
);
    import lzfd_pkg::*;

    logic               mode_reg;
    logic [COUNT_W-1:0] cap_reg;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            cap_reg  <= CAP_RESET;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_MODE: mode_reg <= pwdata[0];
                REG_CAP:  cap_reg  <= pwdata[COUNT_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_MODE: prdata = PDATA_W'(mode_reg);
            REG_CAP:  prdata = PDATA_W'(cap_reg);
            default:  prdata = '0;
        endcase
    end

    assign cfg.mode     = mode_reg;
    assign cfg.capacity = cap_reg;

endmodule

FILE: rtl/lzss_flag_byte_decoder.sv
// LZSS flag-byte decoder top level: parser, command queue, output engine.
// Takes one compressed byte per cycle while the four-entry command queue has
// room; the parser does all limit checks and stream bookkeeping, so bytes
// that give no result (flag bytes, match low bytes, skipped bytes after a
// failure) push no command to the queue. The output engine delivers one
// result per cycle while commands wait and m_ready is high: a literal gives
// one result, a match of n bytes n results, a stream end one status result
// more, so sustained throughput is set by the output side. Copies read a
// HISTORY_DEPTH-byte ring RAM (one write and one read port, registered read,
// with a bypass for the byte being written); it needs no clearing after reset.
// HISTORY_DEPTH may be 2048 to 65536. Registers: offset split mode at 0x0,
// output capacity at 0x4; change them only while the decoder is idle.
module lzss_flag_byte_decoder #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lzfd_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lzfd_pkg::out_item_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lzfd_pkg::PADDR_W-1:0]  paddr,
    input  logic [lzfd_pkg::PDATA_W-1:0]  pwdata,
    output logic [lzfd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import lzfd_pkg::*;

    cfg_t cfg;
    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_head;

    lzfd_top_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lzfd_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    lzfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (q_head)
    );

    lzfd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
